@@ src/brg_pkg.sv @@
// Shared types and constants for the banker's-algorithm grant engine.
`timescale 1ns / 1ps
package brg_pkg;

	// Field widths of a request and of a result
	localparam int CMD_W  = 3;
	localparam int ID_W   = 4;
	localparam int AMT_W  = 8;
	localparam int KIND_W = 3;

	localparam logic [AMT_W-1:0] UNIT_MAX = 8'hFF;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LDAV  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LDCL  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ADMIT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REQ   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REL   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FIN   = 3'd5;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_ACK   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_GRANT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BLOCK = 3'd2;
	localparam logic [KIND_W-1:0] KIND_UNBLK = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REJ   = 3'd4;

	// Operations of the shared arithmetic unit
	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_DEC,
		ALU_SAT8,
		ALU_FIT
	} alu_op_t;

endpackage

@@ src/brg_alu.sv @@
// Shared arithmetic unit: add, decrement, saturating add and need-fits compare.
`timescale 1ns / 1ps
module brg_alu #(
	parameter int W = 13
) (
	input  brg_pkg::alu_op_t op,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	input  logic [W-1:0]     c,
	output logic [W-1:0]     res,
	output logic             fit
);
	import brg_pkg::*;

	logic [W:0]   sum;
	logic [W-1:0] need;

	always_comb begin
		sum  = {1'b0, a} + {1'b0, b};
		// need is claim minus held, floored at zero
		need = (a > b) ? (a - b) : '0;
		fit  = (need <= c);
		unique case (op)
			ALU_ADD:  res = sum[W-1:0];
			ALU_DEC:  res = a - W'(1);
			ALU_SAT8: res = (sum > (W+1)'(UNIT_MAX)) ? W'(UNIT_MAX) : sum[W-1:0];
			ALU_FIT:  res = '0;
			default:  res = '0;
		endcase
	end

endmodule

@@ src/bankers_resource_granter_top.sv @@
// Top level of the banker's-algorithm grant engine: sequencer, tables and queue.
`timescale 1ns / 1ps
// Banker's-algorithm grant engine. A request is taken when start is high and
// busy is low; each request gives one direct result (acknowledged, granted,
// blocked or rejected), then zero or more unblocked-and-granted results, each
// shown for exactly one cycle with strobe high; last marks the final one and
// appears in the first cycle busy is low again. The receiver cannot stall, so
// results must be taken as they come. After reset the engine clears its claim,
// held and available tables, one entry per cycle, with busy high. Loads, admits
// and requests rejected at dispatch pass through the decode, dispatch and finish
// states. A tentative grant that can take a unit runs a safety check on the one
// shared arithmetic unit: a copy of the available table into the work table,
// then scans over the slots in which each running slot is tested against the
// work table and, if it fits, returns its units to it, after which the scan
// starts again from the first slot. A blocked request or a release then retries
// every queued entry; a finish frees the slot's units and its queued entries.
module bankers_resource_granter_top #(
	parameter int PROCS     = 16,
	parameter int RESOURCES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [brg_pkg::CMD_W-1:0]   cmd,
	input  logic [brg_pkg::ID_W-1:0]    slot,
	input  logic [brg_pkg::ID_W-1:0]    resource,
	input  logic [brg_pkg::AMT_W-1:0]   amount,
	output logic                        strobe,
	output logic [brg_pkg::KIND_W-1:0]  kind,
	output logic [brg_pkg::ID_W-1:0]    out_slot,
	output logic [brg_pkg::ID_W-1:0]    out_resource,
	output logic                        last
);
	import brg_pkg::*;

	localparam int PA_W   = $clog2(PROCS);
	localparam int RA_W   = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
	localparam int PC_W   = $clog2(PROCS + 1);
	localparam int RC_W   = $clog2(RESOURCES + 1);
	localparam int CNT_W  = $clog2(PROCS + 1);
	localparam int TAB_N  = PROCS * RESOURCES;
	localparam int TI_W   = $clog2(TAB_N);
	localparam int WORK_W = AMT_W + $clog2(PROCS + 1);
	localparam int XW     = WORK_W - AMT_W;

	// Slot status codes
	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_BLOCK = 2'd2;

	// Sequencer states
	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_CLR      = 5'd1;
	localparam logic [4:0] S_DEC      = 5'd2;
	localparam logic [4:0] S_DSP      = 5'd3;
	localparam logic [4:0] S_REL_B    = 5'd4;
	localparam logic [4:0] S_F_RD     = 5'd5;
	localparam logic [4:0] S_F_WR     = 5'd6;
	localparam logic [4:0] S_DR_RD    = 5'd7;
	localparam logic [4:0] S_DR_D     = 5'd8;
	localparam logic [4:0] S_TG_RD    = 5'd9;
	localparam logic [4:0] S_TG_CHK   = 5'd10;
	localparam logic [4:0] S_TG_HELD  = 5'd11;
	localparam logic [4:0] S_SF_COPY  = 5'd12;
	localparam logic [4:0] S_SF_SCAN  = 5'd13;
	localparam logic [4:0] S_SF_FIT   = 5'd14;
	localparam logic [4:0] S_SF_ADD   = 5'd15;
	localparam logic [4:0] S_SF_END   = 5'd16;
	localparam logic [4:0] S_TG_RST   = 5'd17;
	localparam logic [4:0] S_TG_DONE  = 5'd18;
	localparam logic [4:0] S_RT_START = 5'd19;
	localparam logic [4:0] S_RT_RD    = 5'd20;
	localparam logic [4:0] S_RT_D     = 5'd21;
	localparam logic [4:0] S_FIN      = 5'd22;

	logic [4:0]        state_q;
	logic [TI_W-1:0]   clr_q;

	// Latched request
	logic [CMD_W-1:0]  cmd_q;
	logic [ID_W-1:0]   p_q;
	logic [ID_W-1:0]   r_q;
	logic [AMT_W-1:0]  amt_q;

	// Grant attempt context
	logic [ID_W-1:0]   gp_q;
	logic [ID_W-1:0]   gr_q;
	logic              retry_q;
	logic              ok_q;
	logic [AMT_W-1:0]  avail_q;
	logic [AMT_W-1:0]  held_q;

	// Loop counters
	logic [RC_W-1:0]   ri_q;
	logic              rv_s1;
	logic [RA_W-1:0]   ri_s1;
	logic [PC_W-1:0]   cur_p_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  qi_q;
	logic [CNT_W-1:0]  kept_q;

	logic [1:0]        status_q [PROCS];
	logic [PROCS-1:0]  done_q;
	logic [PROCS-1:0]  run_vec;

	// Held result, flushed when the next one shows up or at the end
	logic              pnd_v_q;
	logic [KIND_W-1:0] pnd_kind_q;
	logic [ID_W-1:0]   pnd_slot_q;
	logic [ID_W-1:0]   pnd_res_q;
	logic              out_v_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [ID_W-1:0]   out_slot_q;
	logic [ID_W-1:0]   out_res_q;
	logic              out_last_q;

	// Memories
	logic [AMT_W-1:0]  avail_mem [RESOURCES];
	logic [WORK_W-1:0] work_mem  [RESOURCES];
	logic [AMT_W-1:0]  claim_mem [TAB_N];
	logic [AMT_W-1:0]  held_mem  [TAB_N];
	logic [7:0]        queue_mem [PROCS];
	logic [AMT_W-1:0]  av_rd_q;
	logic [WORK_W-1:0] wk_rd_q;
	logic [AMT_W-1:0]  cl_rd_q;
	logic [AMT_W-1:0]  hd_rd_q;
	logic [7:0]        q_rd_q;

	// Address conversions
	logic [PA_W+ID_W-1:0] p_x;
	logic [PA_W+ID_W-1:0] gp_x;
	logic [RA_W+ID_W-1:0] r_x;
	logic [RA_W+ID_W-1:0] gr_x;
	logic [PA_W-1:0]   p_a;
	logic [PA_W-1:0]   gp_a;
	logic [RA_W-1:0]   r_a;
	logic [RA_W-1:0]   gr_a;
	logic [RA_W-1:0]   ri_a;
	logic [PA_W-1:0]   cur_a;
	logic [PA_W-1:0]   qi_a;
	logic [PA_W-1:0]   kept_a;
	logic [PA_W-1:0]   count_a;
	logic [PA_W-1:0]   sel_slot;
	logic [RA_W-1:0]   sel_res;
	logic [TI_W-1:0]   tab_a;
	logic [RA_W-1:0]   av_a;

	// Memory write controls
	logic              av_we;
	logic [AMT_W-1:0]  av_wd;
	logic              cl_we;
	logic [AMT_W-1:0]  cl_wd;
	logic              hd_we;
	logic [AMT_W-1:0]  hd_wd;
	logic              wk_we;
	logic [WORK_W-1:0] wk_wd;
	logic              q_we;
	logic [PA_W-1:0]   q_wa;
	logic [7:0]        q_wd;

	// Shared unit
	alu_op_t           alu_op;
	logic [WORK_W-1:0] alu_a;
	logic [WORK_W-1:0] alu_b;
	logic [WORK_W-1:0] alu_c;
	logic [WORK_W-1:0] alu_res;
	logic              alu_fit;

	// Decisions
	logic              pok;
	logic              rok;
	logic              dsp_rej;
	logic              no_unit;
	logic              q_full;
	logic              safe;
	logic              prod;
	logic [KIND_W-1:0] prod_kind;

	brg_alu #(.W(WORK_W)) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.c   (alu_c),
		.res (alu_res),
		.fit (alu_fit)
	);

	assign p_x     = {{PA_W{1'b0}}, p_q};
	assign gp_x    = {{PA_W{1'b0}}, gp_q};
	assign r_x     = {{RA_W{1'b0}}, r_q};
	assign gr_x    = {{RA_W{1'b0}}, gr_q};
	assign p_a     = p_x[PA_W-1:0];
	assign gp_a    = gp_x[PA_W-1:0];
	assign r_a     = r_x[RA_W-1:0];
	assign gr_a    = gr_x[RA_W-1:0];
	assign ri_a    = ri_q[RA_W-1:0];
	assign cur_a   = cur_p_q[PA_W-1:0];
	assign qi_a    = qi_q[PA_W-1:0];
	assign kept_a  = kept_q[PA_W-1:0];
	assign count_a = count_q[PA_W-1:0];

	assign pok     = int'(p_q) < PROCS;
	assign rok     = int'(r_q) < RESOURCES;
	assign no_unit = (av_rd_q == '0) || (hd_rd_q == UNIT_MAX);
	assign q_full  = int'(count_q) >= PROCS;

	// The state is safe once every running slot has been able to finish
	always_comb begin
		for (int k = 0; k < PROCS; k++) begin
			run_vec[k] = (status_q[k] == ST_RUN);
		end
	end
	assign safe = ~|(run_vec & ~done_q);

	// Legality of the latched request, judged with the table data read in S_DEC
	always_comb begin
		unique case (cmd_q)
			CMD_LDAV:  dsp_rej = !rok;
			CMD_LDCL:  dsp_rej = !pok || !rok;
			CMD_ADMIT: dsp_rej = !pok || (status_q[p_a] != ST_FREE);
			CMD_REQ:   dsp_rej = !pok || !rok || (status_q[p_a] != ST_RUN) ||
					(hd_rd_q == UNIT_MAX);
			CMD_REL:   dsp_rej = !pok || !rok || (hd_rd_q == '0);
			CMD_FIN:   dsp_rej = !pok || (status_q[p_a] == ST_FREE);
			default:   dsp_rej = 1'b1;
		endcase
	end

	// Pick the table coordinates each state works on
	always_comb begin
		sel_slot = p_a;
		sel_res  = r_a;
		case (state_q) inside
			S_F_RD, S_F_WR: begin
				sel_res = ri_a;
			end
			S_TG_RD, S_TG_CHK, S_TG_HELD, S_TG_RST: begin
				sel_slot = gp_a;
				sel_res  = gr_a;
			end
			S_SF_COPY: begin
				sel_res = ri_a;
			end
			S_SF_FIT, S_SF_ADD: begin
				sel_slot = cur_a;
				sel_res  = ri_a;
			end
			default: ;
		endcase
		if (state_q == S_CLR) begin
			tab_a = clr_q;
			av_a  = clr_q[RA_W-1:0];
		end else begin
			tab_a = TI_W'(int'(sel_slot) * RESOURCES + int'(sel_res));
			av_a  = sel_res;
		end
	end

	// Memory writes, shared-unit operands and produced results
	always_comb begin
		av_we     = 1'b0;
		av_wd     = alu_res[AMT_W-1:0];
		cl_we     = 1'b0;
		cl_wd     = amt_q;
		hd_we     = 1'b0;
		hd_wd     = alu_res[AMT_W-1:0];
		wk_we     = 1'b0;
		wk_wd     = alu_res;
		q_we      = 1'b0;
		q_wa      = kept_a;
		q_wd      = {gp_q, gr_q};
		alu_op    = ALU_ADD;
		alu_a     = {{XW{1'b0}}, hd_rd_q};
		alu_b     = {{XW{1'b0}}, hd_rd_q};
		alu_c     = wk_rd_q;
		prod      = 1'b0;
		prod_kind = KIND_ACK;
		case (state_q) inside
			S_CLR: begin
				av_we = int'(clr_q) < RESOURCES;
				av_wd = '0;
				cl_we = 1'b1;
				cl_wd = '0;
				hd_we = 1'b1;
				hd_wd = '0;
			end
			S_DSP: begin
				if (dsp_rej) begin
					prod      = 1'b1;
					prod_kind = KIND_REJ;
				end else begin
					case (cmd_q) inside
						CMD_LDAV: begin
							av_we = 1'b1;
							av_wd = amt_q;
							prod  = 1'b1;
						end
						CMD_LDCL: begin
							cl_we = 1'b1;
							prod  = 1'b1;
						end
						CMD_ADMIT: begin
							prod = 1'b1;
						end
						CMD_REL: begin
							alu_op = ALU_DEC;
							hd_we  = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_REL_B: begin
				alu_op = ALU_SAT8;
				alu_a  = {{XW{1'b0}}, avail_q};
				alu_b  = WORK_W'(1);
				av_we  = 1'b1;
				prod   = 1'b1;
			end
			S_F_WR: begin
				alu_op = ALU_SAT8;
				alu_a  = {{XW{1'b0}}, av_rd_q};
				av_we  = 1'b1;
				hd_we  = 1'b1;
				hd_wd  = '0;
			end
			S_DR_RD: begin
				prod = (qi_q == n_q);
			end
			S_DR_D: begin
				q_we = (q_rd_q[7:4] != p_q);
				q_wd = q_rd_q;
			end
			S_TG_CHK: begin
				alu_op = ALU_DEC;
				alu_a  = {{XW{1'b0}}, av_rd_q};
				av_we  = !no_unit;
			end
			S_TG_HELD: begin
				alu_a = {{XW{1'b0}}, held_q};
				alu_b = WORK_W'(1);
				hd_we = 1'b1;
			end
			S_SF_COPY: begin
				wk_we = rv_s1;
				wk_wd = {{XW{1'b0}}, av_rd_q};
			end
			S_SF_FIT: begin
				alu_op = ALU_FIT;
				alu_a  = {{XW{1'b0}}, cl_rd_q};
			end
			S_SF_ADD: begin
				alu_a = wk_rd_q;
				wk_we = rv_s1;
			end
			S_TG_RST: begin
				av_we = 1'b1;
				av_wd = avail_q;
				hd_we = 1'b1;
				hd_wd = held_q;
			end
			S_TG_DONE: begin
				if (retry_q) begin
					prod      = ok_q;
					prod_kind = KIND_UNBLK;
					q_we      = !ok_q;
				end else if (ok_q) begin
					prod      = 1'b1;
					prod_kind = KIND_GRANT;
				end else if (q_full) begin
					prod      = 1'b1;
					prod_kind = KIND_REJ;
				end else begin
					prod      = 1'b1;
					prod_kind = KIND_BLOCK;
					q_we      = 1'b1;
					q_wa      = count_a;
				end
			end
			default: ;
		endcase
	end

	// Tables: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (av_we) begin
			avail_mem[av_a] <= av_wd;
		end
		av_rd_q <= avail_mem[av_a];
	end

	always_ff @(posedge clk) begin
		if (wk_we) begin
			work_mem[ri_s1] <= wk_wd;
		end
		wk_rd_q <= work_mem[ri_a];
	end

	always_ff @(posedge clk) begin
		if (cl_we) begin
			claim_mem[tab_a] <= cl_wd;
		end
		cl_rd_q <= claim_mem[tab_a];
	end

	always_ff @(posedge clk) begin
		if (hd_we) begin
			held_mem[tab_a] <= hd_wd;
		end
		hd_rd_q <= held_mem[tab_a];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_wa] <= q_wd;
		end
		q_rd_q <= queue_mem[qi_a];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			cmd_q      <= '0;
			p_q        <= '0;
			r_q        <= '0;
			amt_q      <= '0;
			gp_q       <= '0;
			gr_q       <= '0;
			retry_q    <= 1'b0;
			ok_q       <= 1'b0;
			avail_q    <= '0;
			held_q     <= '0;
			ri_q       <= '0;
			rv_s1      <= 1'b0;
			ri_s1      <= '0;
			cur_p_q    <= '0;
			count_q    <= '0;
			n_q        <= '0;
			qi_q       <= '0;
			kept_q     <= '0;
			done_q     <= '0;
			pnd_v_q    <= 1'b0;
			pnd_kind_q <= KIND_ACK;
			pnd_slot_q <= '0;
			pnd_res_q  <= '0;
			out_v_q    <= 1'b0;
			out_kind_q <= KIND_ACK;
			out_slot_q <= '0;
			out_res_q  <= '0;
			out_last_q <= 1'b0;
			for (int k = 0; k < PROCS; k++) begin
				status_q[k] <= ST_FREE;
			end
		end else begin
			rv_s1   <= ((state_q == S_SF_COPY) || (state_q == S_SF_FIT) ||
					(state_q == S_SF_ADD)) && (int'(ri_q) < RESOURCES);
			ri_s1   <= ri_a;
			out_v_q <= 1'b0;

			// Flush the held result when a new one arrives, or as the last one
			if (state_q == S_FIN) begin
				out_v_q    <= pnd_v_q;
				out_kind_q <= pnd_kind_q;
				out_slot_q <= pnd_slot_q;
				out_res_q  <= pnd_res_q;
				out_last_q <= 1'b1;
				pnd_v_q    <= 1'b0;
			end else if (prod) begin
				out_v_q    <= pnd_v_q;
				out_kind_q <= pnd_kind_q;
				out_slot_q <= pnd_slot_q;
				out_res_q  <= pnd_res_q;
				out_last_q <= 1'b0;
				pnd_v_q    <= 1'b1;
				pnd_kind_q <= prod_kind;
				pnd_slot_q <= (state_q == S_TG_DONE) ? gp_q : p_q;
				pnd_res_q  <= (state_q == S_TG_DONE) ? gr_q : r_q;
			end

			unique case (state_q)
				S_CLR: begin
					if (int'(clr_q) == TAB_N - 1) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + TI_W'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						p_q     <= slot;
						r_q     <= resource;
						amt_q   <= amount;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_DSP;
				end
				S_DSP: begin
					if (dsp_rej) begin
						state_q <= S_FIN;
					end else begin
						case (cmd_q) inside
							CMD_ADMIT: begin
								status_q[p_a] <= ST_RUN;
								state_q       <= S_FIN;
							end
							CMD_REQ: begin
								gp_q    <= p_q;
								gr_q    <= r_q;
								retry_q <= 1'b0;
								state_q <= S_TG_RD;
							end
							CMD_REL: begin
								avail_q <= av_rd_q;
								state_q <= S_REL_B;
							end
							CMD_FIN: begin
								ri_q    <= '0;
								state_q <= S_F_RD;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_REL_B: begin
					state_q <= S_RT_START;
				end
				S_F_RD: begin
					if (int'(ri_q) == RESOURCES) begin
						status_q[p_a] <= ST_FREE;
						n_q           <= count_q;
						qi_q          <= '0;
						kept_q        <= '0;
						state_q       <= S_DR_RD;
					end else begin
						state_q <= S_F_WR;
					end
				end
				S_F_WR: begin
					ri_q    <= ri_q + RC_W'(1);
					state_q <= S_F_RD;
				end
				S_DR_RD: begin
					if (qi_q == n_q) begin
						count_q <= kept_q;
						state_q <= S_FIN;
					end else begin
						state_q <= S_DR_D;
					end
				end
				S_DR_D: begin
					if (q_we) begin
						kept_q <= kept_q + CNT_W'(1);
					end
					qi_q    <= qi_q + CNT_W'(1);
					state_q <= S_DR_RD;
				end
				S_TG_RD: begin
					// A retried slot runs again for the length of its own check
					status_q[gp_a] <= ST_RUN;
					state_q        <= S_TG_CHK;
				end
				S_TG_CHK: begin
					avail_q <= av_rd_q;
					held_q  <= hd_rd_q;
					if (no_unit) begin
						ok_q    <= 1'b0;
						state_q <= S_TG_DONE;
					end else begin
						state_q <= S_TG_HELD;
					end
				end
				S_TG_HELD: begin
					done_q  <= '0;
					ri_q    <= '0;
					state_q <= S_SF_COPY;
				end
				S_SF_COPY: begin
					if (int'(ri_q) == RESOURCES) begin
						cur_p_q <= '0;
						state_q <= S_SF_SCAN;
					end else begin
						ri_q <= ri_q + RC_W'(1);
					end
				end
				S_SF_SCAN: begin
					if (int'(cur_p_q) == PROCS) begin
						state_q <= S_SF_END;
					end else if ((status_q[cur_a] == ST_RUN) && !done_q[cur_a]) begin
						ri_q    <= '0;
						state_q <= S_SF_FIT;
					end else begin
						cur_p_q <= cur_p_q + PC_W'(1);
					end
				end
				S_SF_FIT: begin
					if (rv_s1 && !alu_fit) begin
						cur_p_q <= cur_p_q + PC_W'(1);
						state_q <= S_SF_SCAN;
					end else if (int'(ri_q) == RESOURCES) begin
						ri_q    <= '0;
						state_q <= S_SF_ADD;
					end else begin
						ri_q <= ri_q + RC_W'(1);
					end
				end
				S_SF_ADD: begin
					if (int'(ri_q) == RESOURCES) begin
						done_q[cur_a] <= 1'b1;
						cur_p_q       <= '0;
						state_q       <= S_SF_SCAN;
					end else begin
						ri_q <= ri_q + RC_W'(1);
					end
				end
				S_SF_END: begin
					ok_q    <= safe;
					state_q <= safe ? S_TG_DONE : S_TG_RST;
				end
				S_TG_RST: begin
					state_q <= S_TG_DONE;
				end
				S_TG_DONE: begin
					if (retry_q) begin
						if (!ok_q) begin
							status_q[gp_a] <= ST_BLOCK;
							kept_q         <= kept_q + CNT_W'(1);
						end
						qi_q    <= qi_q + CNT_W'(1);
						state_q <= S_RT_RD;
					end else if (ok_q || q_full) begin
						state_q <= S_FIN;
					end else begin
						status_q[gp_a] <= ST_BLOCK;
						count_q        <= count_q + CNT_W'(1);
						state_q        <= S_RT_START;
					end
				end
				S_RT_START: begin
					n_q     <= count_q;
					qi_q    <= '0;
					kept_q  <= '0;
					state_q <= S_RT_RD;
				end
				S_RT_RD: begin
					if (qi_q == n_q) begin
						count_q <= kept_q;
						state_q <= S_FIN;
					end else begin
						state_q <= S_RT_D;
					end
				end
				S_RT_D: begin
					gp_q    <= q_rd_q[7:4];
					gr_q    <= q_rd_q[3:0];
					retry_q <= 1'b1;
					state_q <= S_TG_RD;
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign strobe       = out_v_q;
	assign kind         = out_kind_q;
	assign out_slot     = out_slot_q;
	assign out_resource = out_res_q;
	assign last         = out_last_q;

endmodule

@@ src/brg_checker.sv @@
// Port-level checks on the grant engine's result timing, bound to the top level.
`timescale 1ns / 1ps
module brg_props (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        strobe,
	input logic [brg_pkg::KIND_W-1:0]  kind,
	input logic                        last
);
	import brg_pkg::*;

	// An accepted request keeps the engine busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("engine not busy after taking a request");

	// Intermediate results only come while a request is being worked on
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("intermediate result while idle");

	// The final result shows in the first idle cycle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy && $past(busy))
		else $error("final result not aligned with end of busy");

	// Only defined result kinds appear
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> kind <= KIND_REJ)
		else $error("undefined result kind");

endmodule

bind bankers_resource_granter_top brg_props u_brg_props (.*);

@@ bench/brg_checker.sv @@
// Grant-engine checker: predicts the results of each accepted request and compares them.
`timescale 1ns / 1ps
module brg_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [brg_pkg::CMD_W-1:0]          cmd,
	input  logic [brg_pkg::ID_W-1:0]           slot,
	input  logic [brg_pkg::ID_W-1:0]           resource,
	input  logic [brg_pkg::AMT_W-1:0]          amount,
	input  logic                               strobe,
	input  logic [brg_pkg::KIND_W-1:0]         kind,
	input  logic [brg_pkg::ID_W-1:0]           out_slot,
	input  logic [brg_pkg::ID_W-1:0]           out_resource,
	input  logic                               last,
	output int                                 fails,
	output int                                 outstanding
);
	import brg_pkg::*;

	localparam int NP = 16;
	localparam int NR = 16;

	typedef enum logic [1:0] {SLOT_IDLE, SLOT_RUN, SLOT_WAIT} slot_state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   sl;
		logic [ID_W-1:0]   rs;
		logic              lst;
	} grant_note_t;

	logic [AMT_W-1:0] free_units [NR];
	logic [AMT_W-1:0] claim_units [NP][NR];
	logic [AMT_W-1:0] held_units [NP][NR];
	slot_state_t      slot_state [NP];
	logic [7:0]       wait_line [NP];
	int               wait_count;

	grant_note_t due_q[$];
	grant_note_t step_q[$];

	assign outstanding = due_q.size();

	function automatic void note(logic [KIND_W-1:0] k, int s, int r);
		grant_note_t n;
		n.kind = k;
		n.sl   = ID_W'(s);
		n.rs   = ID_W'(r);
		n.lst  = 1'b0;
		step_q.push_back(n);
	endfunction

	// Banker's safety test over running slots only
	function automatic bit ledger_safe();
		int unsigned work [NR];
		bit          done [NP];
		bit          moved;
		bit          fits;
		int unsigned need;
		for (int r = 0; r < NR; r++) work[r] = free_units[r];
		for (int p = 0; p < NP; p++) done[p] = 1'b0;
		moved = 1'b1;
		while (moved) begin
			moved = 1'b0;
			for (int p = 0; p < NP && !moved; p++) begin
				if (slot_state[p] != SLOT_RUN || done[p]) continue;
				fits = 1'b1;
				for (int r = 0; r < NR; r++) begin
					need = (claim_units[p][r] > held_units[p][r]) ?
						claim_units[p][r] - held_units[p][r] : 0;
					if (need > work[r]) fits = 1'b0;
				end
				if (fits) begin
					for (int r = 0; r < NR; r++) work[r] += held_units[p][r];
					done[p] = 1'b1;
					moved = 1'b1;
				end
			end
		end
		for (int p = 0; p < NP; p++)
			if (slot_state[p] == SLOT_RUN && !done[p]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit grant_one(int p, int r);
		if (free_units[r] == 0 || held_units[p][r] == UNIT_MAX) return 1'b0;
		free_units[r]--;
		held_units[p][r]++;
		if (ledger_safe()) return 1'b1;
		free_units[r]++;
		held_units[p][r]--;
		return 1'b0;
	endfunction

	function automatic void retry_waiters();
		int       kept;
		int       p;
		int       r;
		logic [7:0] e;
		kept = 0;
		for (int i = 0; i < wait_count; i++) begin
			e = wait_line[i];
			p = e[7:4];
			r = e[3:0];
			slot_state[p] = SLOT_RUN;
			if (grant_one(p, r)) note(KIND_UNBLK, p, r);
			else begin
				slot_state[p] = SLOT_WAIT;
				wait_line[kept] = e;
				kept++;
			end
		end
		wait_count = kept;
	endfunction

	function automatic void predict_request(logic [CMD_W-1:0] c, int p, int r, logic [AMT_W-1:0] a);
		int kept;
		int sum;
		step_q.delete();
		case (c)
			CMD_LDAV: begin
				free_units[r] = a;
				note(KIND_ACK, p, r);
			end
			CMD_LDCL: begin
				claim_units[p][r] = a;
				note(KIND_ACK, p, r);
			end
			CMD_ADMIT: begin
				if (slot_state[p] != SLOT_IDLE) note(KIND_REJ, p, r);
				else begin
					slot_state[p] = SLOT_RUN;
					note(KIND_ACK, p, r);
				end
			end
			CMD_REQ: begin
				if (slot_state[p] != SLOT_RUN || held_units[p][r] == UNIT_MAX)
					note(KIND_REJ, p, r);
				else if (grant_one(p, r)) note(KIND_GRANT, p, r);
				else if (wait_count >= NP) note(KIND_REJ, p, r);
				else begin
					slot_state[p] = SLOT_WAIT;
					wait_line[wait_count] = {4'(p), 4'(r)};
					wait_count++;
					note(KIND_BLOCK, p, r);
					retry_waiters();
				end
			end
			CMD_REL: begin
				if (held_units[p][r] == 0) note(KIND_REJ, p, r);
				else begin
					held_units[p][r]--;
					if (free_units[r] != UNIT_MAX) free_units[r]++;
					note(KIND_ACK, p, r);
					retry_waiters();
				end
			end
			CMD_FIN: begin
				if (slot_state[p] == SLOT_IDLE) note(KIND_REJ, p, r);
				else begin
					for (int k = 0; k < NR; k++) begin
						sum = free_units[k] + held_units[p][k];
						free_units[k] = (sum > UNIT_MAX) ? UNIT_MAX : AMT_W'(sum);
						held_units[p][k] = '0;
					end
					slot_state[p] = SLOT_IDLE;
					kept = 0;
					for (int i = 0; i < wait_count; i++)
						if (wait_line[i][7:4] != p) begin
							wait_line[kept] = wait_line[i];
							kept++;
						end
					wait_count = kept;
					note(KIND_ACK, p, r);
				end
			end
			default: note(KIND_REJ, p, r);
		endcase
		step_q[$].lst = 1'b1;
		foreach (step_q[i]) due_q.push_back(step_q[i]);
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	initial begin
		fails = 0;
		wait_count = 0;
		for (int r = 0; r < NR; r++) free_units[r] = '0;
		for (int p = 0; p < NP; p++) begin
			slot_state[p] = SLOT_IDLE;
			wait_line[p] = '0;
			for (int r = 0; r < NR; r++) begin
				claim_units[p][r] = '0;
				held_units[p][r]  = '0;
			end
		end
	end

	always @(posedge clk) begin
		grant_note_t head;
		if (arst_n) begin
			if (strobe) begin
				if (due_q.size() == 0) report("unexpected result, kind", kind, 0);
				else begin
					head = due_q.pop_front();
					if (kind !== head.kind) report("kind", kind, head.kind);
					if (out_slot !== head.sl) report("out_slot", out_slot, head.sl);
					if (out_resource !== head.rs) report("out_resource", out_resource, head.rs);
					if (last !== head.lst) report("last", last, head.lst);
				end
			end
			if (start && !busy) predict_request(cmd, int'(slot), int'(resource), amount);
		end
	end
endmodule

@@ bench/bankers_resource_granter_top_test.sv @@
// Testbench top for the grant engine: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module bankers_resource_granter_top_test;
	import brg_pkg::*;

	// Cycles without any request taken or result shown before giving up;
	// a release can retry sixteen queued entries, each a full safety check.
	localparam int STALL_LIMIT = 300000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [CMD_W-1:0]   cmd;
	logic [ID_W-1:0]    slot;
	logic [ID_W-1:0]    resource;
	logic [AMT_W-1:0]   amount;
	logic               strobe;
	logic [KIND_W-1:0]  kind;
	logic [ID_W-1:0]    out_slot;
	logic [ID_W-1:0]    out_resource;
	logic               last;
	int                 fails;
	int                 outstanding;
	int                 quiet_cycles;
	bit                 burst_mode;

	bankers_resource_granter_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .slot(slot), .resource(resource), .amount(amount),
		.strobe(strobe), .kind(kind), .out_slot(out_slot),
		.out_resource(out_resource), .last(last)
	);

	brg_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .slot(slot), .resource(resource), .amount(amount),
		.strobe(strobe), .kind(kind), .out_slot(out_slot),
		.out_resource(out_resource), .last(last),
		.fails(fails), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: count cycles in which neither side moves anything
	always @(posedge clk) begin
		if ((start && !busy) || strobe || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL bankers_resource_granter_top");
			$finish;
		end
	end

	// Issue one request: idle for a random gap, then hold start until the
	// engine is free. Called and returns at a falling edge; start stays high
	// on return while the engine is busy with the request just taken.
	task automatic issue(logic [CMD_W-1:0] c, logic [ID_W-1:0] s,
			logic [ID_W-1:0] r, logic [AMT_W-1:0] a);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd      <= c;
		slot     <= s;
		resource <= r;
		amount   <= a;
		start    <= 1'b1;
		// busy only moves on a rising edge, so its value here holds to the next edge
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	// Hold off until every predicted result has come out
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		int pick;
		int s;
		int r;
		burst_mode = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		slot = '0;
		resource = '0;
		amount = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes of each field and each special case
		issue(CMD_LDAV, 4'd15, 4'd0, 8'd1);          // one unit of resource 0
		issue(CMD_LDAV, 4'd0, 4'd15, 8'd255);
		issue(CMD_LDCL, 4'd0, 4'd0, 8'd1);
		issue(CMD_LDCL, 4'd1, 4'd0, 8'd1);
		issue(CMD_LDCL, 4'd15, 4'd15, 8'd0);
		issue(CMD_REQ, 4'd0, 4'd0, 8'd0);            // slot not running: reject
		issue(CMD_ADMIT, 4'd0, 4'd3, 8'd0);
		issue(CMD_ADMIT, 4'd0, 4'd3, 8'd0);          // already running: reject
		issue(CMD_ADMIT, 4'd1, 4'd0, 8'd0);
		issue(CMD_REQ, 4'd0, 4'd0, 8'd0);            // granted
		issue(CMD_REQ, 4'd1, 4'd0, 8'd0);            // no free unit: blocked
		issue(CMD_REQ, 4'd1, 4'd0, 8'd0);            // blocked slot: reject
		issue(CMD_REL, 4'd0, 4'd0, 8'd0);            // release wakes slot 1
		issue(CMD_REL, 4'd0, 4'd0, 8'd0);            // nothing held: reject
		issue(CMD_FIN, 4'd2, 4'd0, 8'd0);            // free slot: reject
		issue(CMD_FIN, 4'd1, 4'd9, 8'd0);
		issue(3'd6, 4'd15, 4'd15, 8'd255);           // unknown commands
		issue(3'd7, 4'd10, 4'd5, 8'd170);
		issue(CMD_FIN, 4'd0, 4'd0, 8'd0);
		drain();

		// Saturate the free count on a release and on a finish
		burst_mode = 1'b1;
		issue(CMD_LDCL, 4'd15, 4'd15, 8'd3);
		issue(CMD_ADMIT, 4'd15, 4'd0, 8'd0);
		issue(CMD_REQ, 4'd15, 4'd15, 8'd0);
		issue(CMD_REQ, 4'd15, 4'd15, 8'd0);
		issue(CMD_LDAV, 4'd0, 4'd15, 8'd255);
		issue(CMD_REL, 4'd15, 4'd15, 8'd0);          // free count stays at 255
		issue(CMD_LDAV, 4'd0, 4'd15, 8'd255);
		issue(CMD_FIN, 4'd15, 4'd15, 8'd0);          // return saturates at 255
		burst_mode = 1'b0;
		drain();

		// Random: mostly well-formed traffic on a few slots and resources
		for (int n = 0; n < 60; n++) begin
			if ($urandom_range(0, 15) == 0) burst_mode = ~burst_mode;
			if (n == 30) drain();
			if (n % 40 == 0) begin
				for (int k = 0; k < 4; k++)
					issue(CMD_LDAV, 4'($urandom), 4'(k), 8'($urandom_range(1, 4)));
				for (int k = 0; k < 5; k++) begin
					for (int j = 0; j < 3; j++)
						issue(CMD_LDCL, 4'(k), 4'(j), 8'($urandom_range(0, 3)));
					issue(CMD_ADMIT, 4'(k), 4'($urandom), 8'($urandom));
				end
			end
			pick = $urandom_range(0, 99);
			s = $urandom_range(0, 4);
			r = $urandom_range(0, 2);
			if (pick < 45)      issue(CMD_REQ, 4'(s), 4'(r), 8'($urandom));
			else if (pick < 70) issue(CMD_REL, 4'(s), 4'(r), 8'($urandom));
			else if (pick < 77) issue(CMD_FIN, 4'(s), 4'($urandom), 8'($urandom));
			else if (pick < 84) issue(CMD_ADMIT, 4'(s), 4'($urandom), 8'($urandom));
			else if (pick < 88) issue(CMD_LDAV, 4'($urandom), 4'(r), 8'($urandom_range(0, 5)));
			else if (pick < 92) issue(CMD_LDCL, 4'(s), 4'(r), 8'($urandom_range(0, 4)));
			else                issue(3'($urandom), 4'($urandom), 4'($urandom), 8'($urandom));
		end

		// Let the last results come out, then a short settling window
		drain();
		repeat (20) @(negedge clk);
		if (fails == 0 && outstanding == 0) begin
			$display("PASS bankers_resource_granter_top");
		end else begin
			$display("FAIL bankers_resource_granter_top");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
src/brg_pkg.sv
src/brg_alu.sv
src/bankers_resource_granter_top.sv
src/brg_checker.sv
bench/brg_checker.sv
bench/bankers_resource_granter_top_test.sv
